>>> rtl/prfzc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prfzc_pkg
// Shared types, constants and the probe byte maps of the parking radar
// frame zone classifier.
// -----------------------------------------------------------------------------
package prfzc_pkg;

   // number of display positions and width of the position counter
   localparam int POSITIONS = 8;
   localparam int CNT_W     = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

   // frame layout
   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [3:0] STATUS_IDX  = 4'd13;
   localparam logic [3:0] CHECK_IDX   = 4'd14;
   localparam logic [3:0] NO_FRAME    = 4'd15;

   // status bits of frame byte 13
   localparam int FRONT_BIT   = 0;
   localparam int REAR_BIT    = 1;
   localparam int REVERSE_BIT = 2;
   localparam int SPEED_BIT   = 3;

   // reset values
   localparam logic [7:0]  MIN_START     = 8'hFD;
   localparam logic [7:0]  DIST_RESET    = 8'd150;
   localparam logic [7:0]  LIMIT_RESET   = 8'd150;
   localparam logic [31:0] ORDER_RESET   = 32'h8765_4321;
   localparam logic        VARIANT_RESET = 1'b0;

   // floor(x / 3) for x below 512 as (x * 683) >> 11
   localparam logic [9:0] THIRD_MUL   = 10'd683;
   localparam int         THIRD_SHIFT = 11;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_LIMIT   = 2'd0,
      REG_ORDER   = 2'd1,
      REG_VARIANT = 2'd2
   } reg_index_type;

   // alarm zones
   typedef enum logic [2:0] {
      ZONE_MUTE   = 3'd0,
      ZONE_RED    = 3'd1,
      ZONE_YELLOW = 3'd2,
      ZONE_GREEN  = 3'd3,
      ZONE_BLANK  = 3'd4
   } zone_type;

   // shared unit operations
   typedef enum logic {
      OP_MIN   = 1'b0,
      OP_THIRD = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [8:0] a;
      logic [7:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic       flag;
      logic [7:0] value;
   } alu_res_type;

   // frame receiver event toward the sequencer
   typedef struct packed {
      logic done;
      logic good;
   } frame_evt_type;

   // frame byte index for a probe number; 0 means no match
   function automatic logic [3:0] probe_index(input logic variant, input logic [3:0] probe);
      logic [3:0] idx;
      idx = 4'd0;
      if (!variant) begin
         case (probe)
            4'd1: idx = 4'd5;
            4'd2: idx = 4'd6;
            4'd3: idx = 4'd12;
            4'd4: idx = 4'd7;
            4'd5: idx = 4'd1;
            4'd6: idx = 4'd4;
            4'd7: idx = 4'd2;
            4'd8: idx = 4'd3;
            default: idx = 4'd0;
         endcase
      end else begin
         case (probe)
            4'd1:  idx = 4'd5;
            4'd2:  idx = 4'd6;
            4'd3:  idx = 4'd7;
            4'd4:  idx = 4'd8;
            4'd5:  idx = 4'd9;
            4'd6:  idx = 4'd10;
            4'd7:  idx = 4'd11;
            4'd8:  idx = 4'd1;
            4'd9:  idx = 4'd2;
            4'd10: idx = 4'd3;
            default: idx = 4'd0;
         endcase
      end
      return idx;
   endfunction

endpackage

>>> rtl/parking_radar_frame_zone_classifier.sv
`timescale 1ns / 1ps
// Timing: bytes 0 to 13 are taken without stall and give no item. After byte 14 of a
// good frame each position is read and then updated, the thresholds are checked one
// after another, then one item a cycle is loaded while the result channel does not stall;
// a rejected frame gives its item through the fail state once the output register is free.
// Input is stalled from frame end until the last item of that frame is loaded.
// Reset: synchronous; no frame open, distances 150, announced zone blank, registers at defaults.
// -----------------------------------------------------------------------------
// parking_radar_frame_zone_classifier
// Checks radar serial frames, maps probe bytes onto display positions, finds
// the minimum distance and classifies the alarm zone with one shared unit.
// -----------------------------------------------------------------------------
module parking_radar_frame_zone_classifier (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   // result item channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_ok,
   output logic [2:0]  rsp_position,
   output logic [7:0]  rsp_distance,
   output logic [7:0]  rsp_min_distance,
   output logic [2:0]  rsp_zone,
   output logic        rsp_zone_changed,
   output logic        rsp_front_door_open,
   output logic        rsp_rear_door_open,
   output logic        rsp_reversing,
   output logic        rsp_speed_low,
   output logic        rsp_last,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int P = prfzc_pkg::POSITIONS;
   localparam int W = prfzc_pkg::CNT_W;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_RD   = 11'b000_0000_0010,
      S_WR   = 11'b000_0000_0100,
      S_T1   = 11'b000_0000_1000,
      S_C1   = 11'b000_0001_0000,
      S_T2   = 11'b000_0010_0000,
      S_C2   = 11'b000_0100_0000,
      S_C3   = 11'b000_1000_0000,
      S_EMIT = 11'b001_0000_0000,
      S_OUT  = 11'b010_0000_0000,
      S_FAIL = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  limit_ff;
   logic [31:0] order_ff;
   logic        variant_ff;

   logic [W-1:0] cnt_ff, cnt_in;
   logic [7:0]   min_ff, min_in;
   logic [7:0]   thr_ff, thr_in;
   logic         match_ff, match_in;
   logic [2:0]   zone_ff, zone_in;
   logic [2:0]   announced_ff, announced_in;
   logic         chg_ff, chg_in;
   logic [7:0]   dist_ff [P];

   logic         dist_we;
   logic [7:0]   dist_new;
   logic [3:0]   rd_addr;
   logic [7:0]   rd_data;
   logic [3:0]   status;
   logic         mute;
   logic         cnt_last;
   logic         accept;
   logic         out_free;
   logic         load_ok;
   logic         load_fail;

   prfzc_pkg::frame_evt_type evt;
   prfzc_pkg::alu_cmd_type   alu_cmd;
   prfzc_pkg::alu_res_type   alu_res;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_ok_ff;
   logic [2:0]  rsp_pos_ff;
   logic [7:0]  rsp_dist_ff;
   logic [7:0]  rsp_min_ff;
   logic [2:0]  rsp_zone_ff;
   logic        rsp_chg_ff;
   logic [3:0]  rsp_status_ff;
   logic        rsp_last_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_last  = (cnt_ff == W'(P - 1));
   assign mute      = status[prfzc_pkg::FRONT_BIT] || status[prfzc_pkg::REAR_BIT] ||
                      !status[prfzc_pkg::SPEED_BIT];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= prfzc_pkg::LIMIT_RESET;
         order_ff   <= prfzc_pkg::ORDER_RESET;
         variant_ff <= prfzc_pkg::VARIANT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            prfzc_pkg::REG_LIMIT:   limit_ff   <= csr_wdata[7:0];
            prfzc_pkg::REG_ORDER:   order_ff   <= csr_wdata;
            prfzc_pkg::REG_VARIANT: variant_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   prfzc_frame_rx u_frame_rx (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .status      (status),
      .evt         (evt)
   );

   prfzc_alu u_alu (
      .cmd (alu_cmd),
      .res (alu_res)
   );

   // byte index of the probe shown at the current position
   assign rd_addr  = prfzc_pkg::probe_index(variant_ff, order_ff[cnt_ff*4 +: 4]);
   assign dist_new = match_ff ? rd_data : dist_ff[cnt_ff];

   // drive the shared unit from the current step
   always_comb begin
      alu_cmd.op = prfzc_pkg::OP_MIN;
      alu_cmd.a  = {1'b0, min_ff};
      alu_cmd.b  = thr_ff;
      case (state_ff)
         S_WR: begin
            alu_cmd.a = {1'b0, dist_new};
            alu_cmd.b = min_ff;
         end
         S_T1: begin
            alu_cmd.op = prfzc_pkg::OP_THIRD;
            alu_cmd.a  = {1'b0, limit_ff};
         end
         S_T2: begin
            alu_cmd.op = prfzc_pkg::OP_THIRD;
            alu_cmd.a  = {limit_ff, 1'b0};
         end
         S_C3: begin
            alu_cmd.b = limit_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      min_in       = min_ff;
      thr_in       = thr_ff;
      match_in     = match_ff;
      zone_in      = zone_ff;
      announced_in = announced_ff;
      chg_in       = chg_ff;
      dist_we      = 1'b0;
      load_ok      = 1'b0;
      load_fail    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (evt.done) begin
               cnt_in   = '0;
               min_in   = prfzc_pkg::MIN_START;
               state_in = evt.good ? S_RD : S_FAIL;
            end
         end
         S_RD: begin
            match_in = (rd_addr != 4'd0);
            state_in = S_WR;
         end
         S_WR: begin
            dist_we = 1'b1;
            min_in  = alu_res.value;
            if (cnt_last) begin
               if (mute) begin
                  zone_in  = prfzc_pkg::ZONE_MUTE;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_T1;
               end
            end else begin
               cnt_in   = cnt_ff + W'(1);
               state_in = S_RD;
            end
         end
         S_T1: begin
            thr_in   = alu_res.value;
            state_in = S_C1;
         end
         S_C1: begin
            if (alu_res.flag) begin
               zone_in  = prfzc_pkg::ZONE_RED;
               state_in = S_EMIT;
            end else begin
               state_in = S_T2;
            end
         end
         S_T2: begin
            thr_in   = alu_res.value;
            state_in = S_C2;
         end
         S_C2: begin
            if (alu_res.flag) begin
               zone_in  = prfzc_pkg::ZONE_YELLOW;
               state_in = S_EMIT;
            end else begin
               state_in = S_C3;
            end
         end
         S_C3: begin
            zone_in  = alu_res.flag ? prfzc_pkg::ZONE_GREEN : prfzc_pkg::ZONE_BLANK;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            chg_in       = (zone_ff != announced_ff);
            announced_in = zone_ff;
            cnt_in       = '0;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               load_ok = 1'b1;
               if (cnt_last) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + W'(1);
               end
            end
         end
         S_FAIL: begin
            if (out_free) begin
               load_fail = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         announced_ff <= prfzc_pkg::ZONE_BLANK;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         announced_ff <= announced_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff   <= min_in;
      thr_ff   <= thr_in;
      match_ff <= match_in;
      zone_ff  <= zone_in;
      chg_ff   <= chg_in;
   end

   // position distances
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < P; i++) begin
            dist_ff[i] <= prfzc_pkg::DIST_RESET;
         end
      end else if (dist_we) begin
         dist_ff[cnt_ff] <= dist_new;
      end
   end

   // load and drain the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_ok || load_fail) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         rsp_ok_ff     <= 1'b1;
         rsp_pos_ff    <= 3'(cnt_ff);
         rsp_dist_ff   <= dist_ff[cnt_ff];
         rsp_min_ff    <= min_ff;
         rsp_zone_ff   <= zone_ff;
         rsp_chg_ff    <= chg_ff;
         rsp_status_ff <= status;
         rsp_last_ff   <= cnt_last;
      end else if (load_fail) begin
         rsp_ok_ff     <= 1'b0;
         rsp_pos_ff    <= 3'd0;
         rsp_dist_ff   <= 8'd0;
         rsp_min_ff    <= 8'd0;
         rsp_zone_ff   <= prfzc_pkg::ZONE_MUTE;
         rsp_chg_ff    <= 1'b0;
         rsp_status_ff <= 4'd0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_ok        = rsp_ok_ff;
   assign rsp_position        = rsp_pos_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_min_distance    = rsp_min_ff;
   assign rsp_zone            = rsp_zone_ff;
   assign rsp_zone_changed    = rsp_chg_ff;
   assign rsp_front_door_open = rsp_status_ff[prfzc_pkg::FRONT_BIT];
   assign rsp_rear_door_open  = rsp_status_ff[prfzc_pkg::REAR_BIT];
   assign rsp_reversing       = rsp_status_ff[prfzc_pkg::REVERSE_BIT];
   assign rsp_speed_low       = rsp_status_ff[prfzc_pkg::SPEED_BIT];
   assign rsp_last            = rsp_last_ff;

   // a rejected frame gives a single zeroed item
   a_fail_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ok |-> rsp_last && rsp_position == 3'd0 &&
                                     rsp_distance == 8'd0 && rsp_zone == 3'd0)
      else $error("rejected frame item is not a zeroed last item");

   // minimum never exceeds its start value
   a_min_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_min_distance <= prfzc_pkg::MIN_START)
      else $error("minimum distance above cap");

   // a checked frame starts the position walk
   a_good_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && evt.done && evt.good |=> state_ff == S_RD && cnt_ff == '0)
      else $error("good frame did not start the position walk");

   // the announced zone follows the classified zone
   a_announce: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |=> announced_ff == zone_ff && state_ff == S_OUT)
      else $error("announced zone not updated");

   // the mute rule wins over distance classification
   a_mute: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok && (rsp_front_door_open || rsp_rear_door_open ||
                                    !rsp_speed_low) |-> rsp_zone == 3'd0)
      else $error("zone not muted");

endmodule

>>> rtl/prfzc_alu.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prfzc_alu
// Shared arithmetic unit: minimum with less-or-equal flag, and divide by
// three through a reciprocal multiply.
// -----------------------------------------------------------------------------
module prfzc_alu (
   input  prfzc_pkg::alu_cmd_type cmd,
   output prfzc_pkg::alu_res_type res
);

   logic [18:0] prod;
   logic [18:0] shifted;
   logic        le;

   // reciprocal multiply for floor(a / 3)
   assign prod    = 19'(cmd.a) * 19'(prfzc_pkg::THIRD_MUL);
   assign shifted = prod >> prfzc_pkg::THIRD_SHIFT;

   // one comparator serves both minimum search and threshold checks
   assign le = (cmd.a[7:0] <= cmd.b);

   always_comb begin
      case (cmd.op)
         prfzc_pkg::OP_MIN: begin
            res.flag  = le;
            res.value = le ? cmd.a[7:0] : cmd.b;
         end
         prfzc_pkg::OP_THIRD: begin
            res.flag  = 1'b0;
            res.value = shifted[7:0];
         end
         default: begin
            res.flag  = 1'b0;
            res.value = 8'd0;
         end
      endcase
   end

endmodule

>>> rtl/prfzc_frame_rx.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prfzc_frame_rx
// Frame byte capture: byte counter, running checksum, header check, status
// capture and the frame byte memory with a registered read port.
// -----------------------------------------------------------------------------
module prfzc_frame_rx (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               rx_byte,
   input  logic                     frame_start,
   input  logic [3:0]               rd_addr,
   output logic [7:0]               rd_data,
   output logic [3:0]               status,
   output prfzc_pkg::frame_evt_type evt
);

   logic [3:0] byte_pos_ff, byte_pos_in;
   logic [7:0] sum_ff, sum_in;
   logic       hdr_ok_ff;
   logic [3:0] status_ff;
   logic [7:0] rd_data_ff;
   logic [7:0] mem [16];
   logic       active;
   logic [3:0] pos;

   // effective byte index of this item
   assign active = frame_start || (byte_pos_ff != prfzc_pkg::NO_FRAME);
   assign pos    = frame_start ? 4'd0 : byte_pos_ff;

   // advance counter and checksum
   always_comb begin
      byte_pos_in = byte_pos_ff;
      sum_in      = frame_start ? 8'd0 : sum_ff;
      if (accept && active) begin
         if (pos < prfzc_pkg::CHECK_IDX) begin
            byte_pos_in = pos + 4'd1;
            if (pos != 4'd0) begin
               sum_in = sum_in + rx_byte;
            end
         end else begin
            byte_pos_in = prfzc_pkg::NO_FRAME;
         end
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= prfzc_pkg::NO_FRAME;
         sum_ff      <= 8'd0;
      end else begin
         byte_pos_ff <= byte_pos_in;
         sum_ff      <= sum_in;
      end
   end

   // hold header check and status nibble of the open frame
   always_ff @(posedge clock) begin
      if (accept && active && pos == 4'd0) begin
         hdr_ok_ff <= (rx_byte == prfzc_pkg::HEADER_BYTE);
      end
      if (accept && active && pos == prfzc_pkg::STATUS_IDX) begin
         status_ff <= rx_byte[3:0];
      end
   end

   // frame byte memory
   always_ff @(posedge clock) begin
      if (accept && active) begin
         mem[pos] <= rx_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign status   = status_ff;
   assign evt.done = accept && active && (pos == prfzc_pkg::CHECK_IDX);
   assign evt.good = hdr_ok_ff && (rx_byte == sum_ff);

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parking radar frame zone classifier. Radar
// frames, good and broken, are fed one byte per item, with random gaps on
// both sides in the first four phases; a local model of the frame checker,
// probe mapping and zone rules predicts every result item, which is compared in arrival order.
// -----------------------------------------------------------------------------
module tb_top;

   // probe number to frame byte index, nibble p holds the index for probe p
   localparam logic [63:0] MAP_EIGHT     = 64'h0000_0003_2417_C650;
   localparam logic [63:0] MAP_TEN       = 64'h0000_0321_BA98_7650;
   localparam int          SETTLE_CYCLES = 4 * prfzc_pkg::POSITIONS + 8;
   localparam int          WATCHDOG_MAX  = 2000;
   localparam int          PHASE_ITEMS   = 78;

   typedef struct packed {
      logic [7:0] rx;
      logic       start;
   } rx_item_type;

   typedef struct packed {
      logic                ok;
      logic [2:0]          position;
      logic [7:0]          distance;
      logic [7:0]          min_distance;
      prfzc_pkg::zone_type zone;
      logic                changed;
      logic [3:0]          status;
      logic                last;
   } zone_report_type;

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte         = 8'd0;
   logic        req_frame_start     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic        rsp_frame_ok;
   logic [2:0]  rsp_position;
   logic [7:0]  rsp_distance;
   logic [7:0]  rsp_min_distance;
   logic [2:0]  rsp_zone;
   logic        rsp_zone_changed;
   logic        rsp_front_door_open;
   logic        rsp_rear_door_open;
   logic        rsp_reversing;
   logic        rsp_speed_low;
   logic        rsp_last;
   logic        csr_valid           = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index           = prfzc_pkg::REG_LIMIT;
   logic [31:0] csr_wdata           = 32'd0;

   // stimulus and expectation stores
   rx_item_type     rx_items_q[$];
   zone_report_type zone_report_q[$];
   logic [7:0]      frame_bytes[15];

   // mirrored registers and radar state
   logic [7:0]          cfg_limit   = prfzc_pkg::LIMIT_RESET;
   logic [31:0]         cfg_order   = prfzc_pkg::ORDER_RESET;
   logic                cfg_variant = prfzc_pkg::VARIANT_RESET;
   logic [7:0]          frame_store[16];
   logic [3:0]          frame_pos   = prfzc_pkg::NO_FRAME;
   logic [7:0]          frame_sum   = 8'd0;
   logic [7:0]          pos_dist[prfzc_pkg::POSITIONS];
   prfzc_pkg::zone_type shown_zone  = prfzc_pkg::ZONE_BLANK;

   int          send_gap_pct    = 0;
   int          recv_gap_pct    = 0;
   logic        req_accepted    = 1'b0;
   int          stall_cycles    = 0;
   int          frame_items     = 0;
   int          error_count     = 0;
   int          results_checked = 0;
   int          good_frames     = 0;
   int          rejected_frames = 0;
   int          ignored_bytes   = 0;
   logic [4:0]  zones_seen      = 5'd0;

   parking_radar_frame_zone_classifier u_top (.*);

   always #1 clock = ~clock;

   // advance the radar model by one accepted byte and queue what it reports
   task automatic classify_byte(input logic [7:0] rx, input logic start);
      logic [63:0]         byte_map;
      logic [3:0]          probe;
      logic [3:0]          idx;
      logic [7:0]          low;
      logic [3:0]          status;
      int                  lim;
      prfzc_pkg::zone_type zone;
      zone_report_type     r;
      if (!start && frame_pos == prfzc_pkg::NO_FRAME) begin
         ignored_bytes++;
      end else begin
         if (start) begin
            frame_pos = 4'd0;
            frame_sum = 8'd0;
         end
         frame_store[frame_pos] = rx;
         if (frame_pos < prfzc_pkg::CHECK_IDX) begin
            if (frame_pos != 4'd0) frame_sum = frame_sum + rx;
            frame_pos = frame_pos + 4'd1;
         end else begin
            frame_pos = prfzc_pkg::NO_FRAME;
            if (frame_store[0] != prfzc_pkg::HEADER_BYTE || rx != frame_sum) begin
               // bad header or checksum: one failure item, nothing updated
               r      = '0;
               r.zone = prfzc_pkg::ZONE_MUTE;
               r.last = 1'b1;
               zone_report_q.push_back(r);
               rejected_frames++;
            end else begin
               // map probe bytes onto positions, unmatched probes hold
               byte_map = cfg_variant ? MAP_TEN : MAP_EIGHT;
               for (int i = 0; i < prfzc_pkg::POSITIONS; i++) begin
                  probe = cfg_order[4*i +: 4];
                  idx   = byte_map[4*probe +: 4];
                  if (idx != 4'd0) pos_dist[i] = frame_store[idx];
               end
               low = prfzc_pkg::MIN_START;
               for (int i = 0; i < prfzc_pkg::POSITIONS; i++)
                  if (pos_dist[i] < low) low = pos_dist[i];
               // classify against the thirds of the limit
               status = frame_store[prfzc_pkg::STATUS_IDX][3:0];
               lim    = cfg_limit;
               if (status[prfzc_pkg::FRONT_BIT] || status[prfzc_pkg::REAR_BIT] ||
                   !status[prfzc_pkg::SPEED_BIT])
                  zone = prfzc_pkg::ZONE_MUTE;
               else if (low <= lim / 3)
                  zone = prfzc_pkg::ZONE_RED;
               else if (low <= (2 * lim) / 3)
                  zone = prfzc_pkg::ZONE_YELLOW;
               else if (low <= lim)
                  zone = prfzc_pkg::ZONE_GREEN;
               else
                  zone = prfzc_pkg::ZONE_BLANK;
               r.ok           = 1'b1;
               r.min_distance = low;
               r.zone         = zone;
               r.changed      = (zone != shown_zone);
               r.status       = status;
               shown_zone       = zone;
               zones_seen[zone] = 1'b1;
               for (int i = 0; i < prfzc_pkg::POSITIONS; i++) begin
                  r.position = 3'(i);
                  r.distance = pos_dist[i];
                  r.last     = (i == prfzc_pkg::POSITIONS - 1);
                  zone_report_q.push_back(r);
               end
               good_frames++;
            end
         end
      end
   endtask

   function automatic string describe(zone_report_type r);
      return $sformatf("ok=%b pos=%0d dist=%0d min=%0d zone=%0d chg=%b status=%b last=%b",
                       r.ok, r.position, r.distance, r.min_distance, r.zone, r.changed,
                       r.status, r.last);
   endfunction

   // drive the byte channel and the result stall at the falling edge
   always @(negedge clock) begin : byte_driver
      rx_item_type it;
      if (!reset && (!req_valid || req_accepted)) begin
         if (rx_items_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            it = rx_items_q.pop_front();
            req_valid       <= 1'b1;
            req_rx_byte     <= it.rx;
            req_frame_start <= it.start;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_gap_pct);
   end

   // predict on every accepted byte
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) classify_byte(req_rx_byte, req_frame_start);
   end

   // compare every accepted result item with the oldest prediction
   always @(posedge clock) begin : result_check
      zone_report_type got;
      zone_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_frame_ok, rsp_position, rsp_distance, rsp_min_distance, rsp_zone,
                rsp_zone_changed,
                {rsp_speed_low, rsp_reversing, rsp_rear_door_open, rsp_front_door_open},
                rsp_last};
         if (zone_report_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result item: %s", describe(got));
         end else begin
            want = zone_report_q.pop_front();
            results_checked++;
            if (got !== want) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("result mismatch, expected %s", describe(want));
                  $display("                 actual   %s", describe(got));
               end
            end
         end
      end
   end

   // end the run when no handshake completes for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_MAX) begin
         $display("[parking_radar_frame_zone_classifier] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(input prfzc_pkg::reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         prfzc_pkg::REG_LIMIT:   cfg_limit   = value[7:0];
         prfzc_pkg::REG_ORDER:   cfg_order   = value;
         prfzc_pkg::REG_VARIANT: cfg_variant = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold until all bytes are in and all results out, then let the block drain
   task automatic settle();
      while (rx_items_q.size() != 0 || req_valid || zone_report_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_item(input logic [7:0] rx, input logic start);
      rx_item_type it;
      it.rx    = rx;
      it.start = start;
      rx_items_q.push_back(it);
   endtask

   // queue the first n_bytes of frame_bytes, with a good or corrupted checksum
   task automatic queue_frame(input int n_bytes, input logic fix_sum);
      logic [7:0] sum;
      sum = 8'd0;
      for (int k = 1; k < 14; k++) sum = sum + frame_bytes[k];
      frame_bytes[14] = fix_sum ? sum : sum + 8'($urandom_range(255, 1));
      for (int k = 0; k < n_bytes; k++) push_item(frame_bytes[k], k == 0);
      frame_items += n_bytes;
   endtask

   // fill distances around a per-frame floor, often right at a zone edge
   task automatic fill_payload();
      int base;
      int spread;
      int t;
      int v;
      frame_bytes[0] = prfzc_pkg::HEADER_BYTE;
      spread = $urandom_range(40);
      case ($urandom_range(3))
         0: base = $urandom_range(255);
         1: base = $urandom_range(cfg_limit);
         2: begin
            case ($urandom_range(2))
               0:       t = cfg_limit / 3;
               1:       t = (2 * cfg_limit) / 3;
               default: t = cfg_limit;
            endcase
            base   = t + $urandom_range(2) - 1;
            spread = 0;
         end
         default: begin
            base   = 0;
            spread = 255;
         end
      endcase
      if (base < 0) base = 0;
      for (int k = 1; k < 13; k++) begin
         v = base + $urandom_range(spread);
         frame_bytes[k] = (v > 255) ? 8'd255 : 8'(v);
      end
      // mostly doors closed and low speed so the distance zones are reached
      frame_bytes[13] = {4'($urandom()),
                         ($urandom_range(99) < 70) ? {1'b1, 1'($urandom()), 2'b00}
                                                   : 4'($urandom())};
   endtask

   task automatic queue_random_frame();
      int kind;
      fill_payload();
      kind = $urandom_range(99);
      if (kind < 70) begin
         queue_frame(15, 1'b1);
      end else if (kind < 78) begin
         frame_bytes[0] = 8'($urandom());
         if (frame_bytes[0] == prfzc_pkg::HEADER_BYTE) frame_bytes[0] = ~prfzc_pkg::HEADER_BYTE;
         queue_frame(15, 1'b1);
      end else if (kind < 86) begin
         queue_frame(15, 1'b0);
      end else if (kind < 93) begin
         // cut short, the next start mark drops it
         queue_frame($urandom_range(14, 1), 1'b1);
      end else begin
         repeat ($urandom_range(3, 1)) push_item(8'($urandom()), 1'b0);
      end
   endtask

   initial begin : stimulus
      int phase;
      for (int i = 0; i < prfzc_pkg::POSITIONS; i++) pos_dist[i] = prfzc_pkg::DIST_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 6; phase++) begin
         settle();
         case (phase / 2)
            0: begin
               send_gap_pct = 11;
               recv_gap_pct = 63;
            end
            1: begin
               send_gap_pct = 63;
               recv_gap_pct = 11;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
            end
         endcase

         // new register setting for this phase
         case (phase)
            0: begin
               write_reg(prfzc_pkg::REG_LIMIT, {24'($urandom()), 8'd255});
               write_reg(prfzc_pkg::REG_ORDER, prfzc_pkg::ORDER_RESET);
               write_reg(prfzc_pkg::REG_VARIANT, {31'($urandom()), 1'b0});
            end
            1: begin
               write_reg(prfzc_pkg::REG_LIMIT, {24'($urandom()), 8'd0});
               write_reg(prfzc_pkg::REG_ORDER, 32'hA987_6543);
               write_reg(prfzc_pkg::REG_VARIANT, {31'($urandom()), 1'b1});
            end
            4: begin
               write_reg(prfzc_pkg::REG_LIMIT, 32'd1);
               write_reg(prfzc_pkg::REG_ORDER, 32'hF0F0_9A3B);
               write_reg(prfzc_pkg::REG_VARIANT, 32'd1);
            end
            default: begin
               write_reg(prfzc_pkg::REG_LIMIT, $urandom());
               write_reg(prfzc_pkg::REG_ORDER, $urandom());
               write_reg(prfzc_pkg::REG_VARIANT, (phase == 3) ? 32'd0 : $urandom());
            end
         endcase

         if (phase == 0) begin
            // drop bytes with no frame open
            push_item(8'h00, 1'b0);
            push_item(8'hFF, 1'b0);
            // restart over a partial frame
            fill_payload();
            queue_frame(4, 1'b1);
            // far targets everywhere: minimum capped below 254
            for (int k = 1; k < 13; k++) frame_bytes[k] = 8'hFF;
            frame_bytes[13] = 8'hF8;
            queue_frame(15, 1'b1);
         end

         while (frame_items < PHASE_ITEMS * (phase + 1)) queue_random_frame();
      end

      settle();
      $display("covered %0d good frames, %0d rejected frames, %0d bytes outside a frame",
               good_frames, rejected_frames, ignored_bytes);
      $display("zones reached (blank..mute) %b, %0d result items checked, %0d mismatches",
               zones_seen, results_checked, error_count);
      if (error_count == 0 && zone_report_q.size() == 0) begin
         $display("[parking_radar_frame_zone_classifier] OK");
      end else begin
         $display("[parking_radar_frame_zone_classifier] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/prfzc_pkg.sv
rtl/prfzc_alu.sv
rtl/prfzc_frame_rx.sv
rtl/parking_radar_frame_zone_classifier.sv
verif/tb_top.sv
